/* hw/rtl/mrrc_pkg.sv */
// Shared types, constants and the byte-wise CRC-16 step of the reply checker.
package mrrc_pkg;

    localparam int FRAME_BYTES = 7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] ADDR_RESET = 8'hFE;
    localparam logic [7:0] FUNC_RESET = 8'h04;

    // Configuration register indexes
    localparam logic CFG_ADDR = 1'b0;
    localparam logic CFG_FUNC = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HDR_BAD = 2'd1,
        ST_CRC_BAD = 2'd2
    } t_status;

    typedef struct packed {
        logic        emit;
        logic [15:0] reading;
        t_status     status;
    } t_result;

    // Fold one byte into a reflected CRC-16, one bit per step
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/mrrc_crc16.sv */
// Byte-wise CRC-16 update with restart select.
module mrrc_crc16
    import mrrc_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic        i_restart,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc_base,
    output logic [15:0] o_crc_next
);

    // Pick the running value or the initial value, then fold in the byte
    assign o_crc_base = i_restart ? CRC_INIT : i_crc;
    assign o_crc_next = crc_feed(o_crc_base, i_byte);

endmodule

/* hw/rtl/mrrc_frame.sv */
// Frame tracking: byte position, header check, value and CRC capture, status.
module mrrc_frame
    import mrrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    input  logic [7:0]  i_exp_addr,
    input  logic [7:0]  i_exp_func,
    output t_result     o_result
);

    localparam logic [2:0] POS_CRC_LO = 3'(FRAME_BYTES - 2);
    localparam logic [2:0] POS_LAST   = 3'(FRAME_BYTES - 1);

    logic [2:0]  r_pos;
    logic [15:0] r_crc;
    logic [15:0] r_value;
    logic        r_hdr_good;
    logic [7:0]  r_crc_lo;

    logic [2:0]  w_pos;
    logic        w_hdr_base;
    logic        w_hdr_next;
    logic [15:0] w_crc_base;
    logic [15:0] w_crc_next;
    logic        w_last;
    logic [15:0] w_got;
    t_status     w_status;

    mrrc_crc16 u_crc (
        .i_crc      (r_crc),
        .i_restart  (i_frame_start),
        .i_byte     (i_rx_byte),
        .o_crc_base (w_crc_base),
        .o_crc_next (w_crc_next)
    );

    // Restart position and header flag on a frame-start mark
    assign w_pos      = i_frame_start ? 3'd0 : r_pos;
    assign w_hdr_base = i_frame_start ? 1'b1 : r_hdr_good;
    assign w_last     = (w_pos >= POS_LAST);
    assign w_got      = {i_rx_byte, r_crc_lo};

    // Clear the header flag on an address or function mismatch
    always_comb begin
        w_hdr_next = w_hdr_base;
        if (w_pos == 3'd0 && i_rx_byte != i_exp_addr) begin
            w_hdr_next = 1'b0;
        end
        if (w_pos == 3'd1 && i_rx_byte != i_exp_func) begin
            w_hdr_next = 1'b0;
        end
    end

    // Form the status of the last byte
    always_comb begin
        if (!w_hdr_base) begin
            w_status = ST_HDR_BAD;
        end else if (w_got != w_crc_base) begin
            w_status = ST_CRC_BAD;
        end else begin
            w_status = ST_OK;
        end
        o_result.emit    = w_last;
        o_result.status  = w_status;
        o_result.reading = (w_status == ST_OK) ? r_value : 16'h0000;
    end

    // Advance control state per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 3'd0;
            r_crc      <= CRC_INIT;
            r_hdr_good <= 1'b1;
            r_value    <= 16'h0000;
            r_crc_lo   <= 8'h00;
        end else if (i_step) begin
            if (w_last) begin
                r_pos      <= 3'd0;
                r_crc      <= CRC_INIT;
                r_hdr_good <= 1'b1;
            end else begin
                r_pos      <= w_pos + 3'd1;
                r_hdr_good <= w_hdr_next;
                r_crc      <= (w_pos < POS_CRC_LO) ? w_crc_next : w_crc_base;
            end
            if (w_pos == 3'd3) begin
                r_value[15:8] <= i_rx_byte;
            end
            if (w_pos == 3'd4) begin
                r_value[7:0] <= i_rx_byte;
            end
            if (w_pos == POS_CRC_LO) begin
                r_crc_lo <= i_rx_byte;
            end
        end
    end

endmodule

/* hw/rtl/modbus_register_reply_checker_core.sv */
// Top level: input register, frame checker, result register, config registers.
// The last byte of a frame is taken into the input register, checked and then
// registered in the result register, from where the result can transfer.
// Throughput: one byte per cycle while the receiver does not stall; the input
// register feeds one combinational CRC and header stage that writes the result
// register. Reset (synchronous, active low) empties both registers, restarts
// the frame and loads address 0xFE and function 0x04.
module modbus_register_reply_checker_core
    import mrrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_reading,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_rx_byte;
    logic        r_frame_start;
    logic        r_out_valid;
    logic [15:0] r_reading;
    t_status     r_status;
    logic [7:0]  r_exp_addr;
    logic [7:0]  r_exp_func;

    logic        w_adv;
    logic        w_step;
    t_result     w_result;

    // Advance whenever the result register is free or being drained
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_reading   = r_reading;
    assign o_status    = r_status;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr <= ADDR_RESET;
            r_exp_func <= FUNC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ADDR: r_exp_addr <= i_cfg_data;
                CFG_FUNC: r_exp_func <= i_cfg_data;
                default:  r_exp_addr <= r_exp_addr;
            endcase
        end
    end

    // Capture an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_rx_byte     <= i_rx_byte;
            r_frame_start <= i_frame_start;
        end
    end

    mrrc_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_rx_byte     (r_rx_byte),
        .i_frame_start (r_frame_start),
        .i_exp_addr    (r_exp_addr),
        .i_exp_func    (r_exp_func),
        .o_result      (w_result)
    );

    // Load the result register; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && w_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.emit) begin
            r_reading <= w_result.reading;
            r_status  <= w_result.status;
        end
    end

endmodule

/* bench/mrrc_reply_monitor.sv */
`timescale 1ns / 1ps
// Reply monitor: watches the byte, result and register channels and checks each result.
module mrrc_reply_monitor
    import mrrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_reading,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_pending,
    output int          o_errors
);

    localparam logic [15:0] SEED_CRC  = 16'hFFFF;
    localparam logic [15:0] REFL_POLY = 16'hA001;

    typedef struct packed {
        logic [15:0] reading;
        t_status     status;
    } t_reply;

    t_reply      replies_due[$];
    logic [7:0]  want_addr = ADDR_RESET;
    logic [7:0]  want_func = FUNC_RESET;
    logic [2:0]  frame_pos = 3'd0;
    logic [15:0] crc_acc = SEED_CRC;
    logic [15:0] value_acc = 16'h0000;
    logic        header_ok = 1'b1;
    logic [7:0]  crc_lo_seen = 8'h00;
    int          mismatch_count = 0;

    // Shift one byte through the reflected CRC-16, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = (c >> 1) ^ (c[0] ? REFL_POLY : 16'h0000);
        return c;
    endfunction

    task automatic restart_frame();
        frame_pos = 3'd0;
        crc_acc   = SEED_CRC;
        header_ok = 1'b1;
    endtask

    // Advance the frame state by one byte; queue a reply on the last byte
    task automatic absorb_byte(input logic [7:0] b, input logic fs);
        t_reply r;
        if (fs) restart_frame();
        if (frame_pos < FRAME_BYTES - 2) crc_acc = crc_byte(crc_acc, b);
        if (frame_pos == 3'd0 && b != want_addr) header_ok = 1'b0;
        if (frame_pos == 3'd1 && b != want_func) header_ok = 1'b0;
        if (frame_pos == 3'd3) value_acc[15:8] = b;
        if (frame_pos == 3'd4) value_acc[7:0] = b;
        if (frame_pos == FRAME_BYTES - 2) crc_lo_seen = b;
        if (frame_pos >= FRAME_BYTES - 1) begin
            if (!header_ok) begin
                r.status = ST_HDR_BAD;
            end else if ({b, crc_lo_seen} != crc_acc) begin
                r.status = ST_CRC_BAD;
            end else begin
                r.status = ST_OK;
            end
            r.reading = (r.status == ST_OK) ? value_acc : 16'h0000;
            replies_due.push_back(r);
            restart_frame();
        end else begin
            frame_pos = frame_pos + 3'd1;
        end
    endtask

    // Track register writes, compare results, predict from accepted bytes
    always @(posedge i_clk) begin
        t_reply due;
        if (!i_rst_n) begin
            want_addr   = ADDR_RESET;
            want_func   = FUNC_RESET;
            value_acc   = 16'h0000;
            crc_lo_seen = 8'h00;
            restart_frame();
            replies_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ADDR) begin
                    want_addr = i_cfg_data;
                end else begin
                    want_func = i_cfg_data;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected result: reading %h status %0d", i_reading, i_status);
                    mismatch_count++;
                end else begin
                    due = replies_due.pop_front();
                    if (i_reading !== due.reading) begin
                        $error("reading: expected %h, got %h", due.reading, i_reading);
                        mismatch_count++;
                    end
                    if (i_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, i_status);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) absorb_byte(i_rx_byte, i_frame_start);
        end
        o_pending <= replies_due.size();
        o_errors  <= mismatch_count;
    end

endmodule

/* bench/modbus_register_reply_checker_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, frame and register stimulus, receiver stalls and verdict.
module modbus_register_reply_checker_core_tb;
    import mrrc_pkg::*;

    localparam int GAP_MAX      = 19;
    localparam int SETTLE       = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_BYTES  = 250;
    localparam int PHASES       = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        frame_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [15:0] reading;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ADDR;
    logic [7:0]  cfg_data = 8'h00;
    int          pending;
    int          errors;

    logic [7:0]  cur_addr = ADDR_RESET;
    logic [7:0]  cur_func = FUNC_RESET;
    bit          fast_send = 1'b0;
    bit          fast_recv = 1'b0;
    bit          hold_req = 1'b0;
    bit          need_start = 1'b1;
    int          bytes_sent = 0;
    int          idle_cycles = 0;

    modbus_register_reply_checker_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_rx_byte     (rx_byte),
        .i_frame_start (frame_start),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_reading     (reading),
        .o_status      (status),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    mrrc_reply_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_rx_byte     (rx_byte),
        .i_frame_start (frame_start),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_reading     (reading),
        .i_status      (status),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("modbus_register_reply_checker_core_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one byte, after a random gap unless sending fast, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= fs;
        do @(posedge clk); while (in_stall !== 1'b0);
        bytes_sent++;
    endtask

    // Build a reply frame, optionally corrupt its CRC, send its first nbytes bytes
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] cnt, input logic [15:0] val,
                              input logic [15:0] crc_flip, input int nbytes,
                              input logic fs);
        logic [7:0]  fb [7];
        logic [15:0] c;
        fb[0] = addr;
        fb[1] = func;
        fb[2] = cnt;
        fb[3] = val[15:8];
        fb[4] = val[7:0];
        c = 16'hFFFF;
        for (int k = 0; k < 5; k++) begin
            c ^= {8'h00, fb[k]};
            for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        c ^= crc_flip;
        fb[5] = c[7:0];
        fb[6] = c[15:8];
        for (int k = 0; k < nbytes; k++) send_byte(fb[k], (k == 0) ? fs : 1'b0);
    endtask

    // Mostly well-formed frames; the rest header errors, CRC errors, cut frames, noise
    task automatic random_frame();
        int          kind;
        logic [7:0]  a;
        logic [7:0]  f;
        logic [7:0]  cnt;
        logic [15:0] val;
        logic [15:0] flip;
        logic        fs;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0) fast_send = ~fast_send;
        case ($urandom_range(0, 9))
            0:       val = 16'h0000;
            1:       val = 16'hFFFF;
            default: val = 16'($urandom);
        endcase
        cnt  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd2;
        a    = cur_addr;
        f    = cur_func;
        flip = 16'h0000;
        fs   = need_start ? 1'b1 : ($urandom_range(0, 5) != 0);
        need_start = 1'b0;
        if (kind < 60) begin
            send_frame(a, f, cnt, val, flip, 7, fs);
        end else if (kind < 70) begin
            a = cur_addr ^ 8'($urandom_range(1, 255));
            send_frame(a, f, cnt, val, flip, 7, fs);
        end else if (kind < 78) begin
            f = cur_func ^ 8'($urandom_range(1, 255));
            send_frame(a, f, cnt, val, flip, 7, fs);
        end else if (kind < 88) begin
            flip = 16'($urandom_range(1, 16'hFFFF));
            send_frame(a, f, cnt, val, flip, 7, fs);
        end else if (kind < 94) begin
            send_frame(a, f, cnt, val, flip, $urandom_range(1, 6), fs);
            need_start = 1'b1;
        end else begin
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom), 1'($urandom));
            need_start = 1'b1;
        end
    endtask

    // Stop offering bytes and wait until every expected reply has come
    task automatic drain();
        in_valid <= 1'b0;
        repeat (SETTLE) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stall per reply, one long hold on request
    initial begin
        int wait_n;
        bit hold_done;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            wait_n = fast_recv ? 0 : $urandom_range(0, GAP_MAX);
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            if ($urandom_range(0, 7) == 0) fast_recv = ~fast_recv;
        end
    end

    // Stimulus and verdict
    initial begin
        logic [7:0] a;
        logic [7:0] f;
        int         goal;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset address and function
        send_frame(cur_addr, cur_func, 8'd2, 16'hFFFF, 16'h0000, 7, 1'b1);
        // abandoned mid-frame by a new frame-start mark
        send_frame(cur_addr, cur_func, 8'h00, 16'h1234, 16'h0000, 3, 1'b1);
        // wrong address and bad CRC together: header error takes precedence
        send_frame(8'h00, cur_func, 8'hFF, 16'h0000, 16'h8001, 7, 1'b1);
        // next frame follows without a frame-start mark
        send_frame(cur_addr, cur_func, 8'd2, 16'h0000, 16'h0000, 7, 1'b0);
        drain();

        // Register settings, extremes first, each followed by random frames
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin a = 8'h00; f = 8'h00; end
                1:       begin a = 8'hFF; f = 8'hFF; end
                2:       begin a = 8'h01; f = 8'h80; end
                default: begin a = 8'($urandom); f = 8'($urandom); end
            endcase
            write_reg(CFG_ADDR, a);
            write_reg(CFG_FUNC, f);
            cur_addr   = a;
            cur_func   = f;
            need_start = 1'b1;
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal) random_frame();
            drain();
            if (ph == 2) begin
                // hold the receiver off while good frames keep coming back to back
                hold_req  = 1'b1;
                fast_send = 1'b1;
                repeat (6) send_frame(cur_addr, cur_func, 8'd2, 16'($urandom), 16'h0000, 7, 1'b1);
                drain();
            end
        end

        if (errors == 0) begin
            $display("modbus_register_reply_checker_core_tb: done, clean");
        end else begin
            $display("modbus_register_reply_checker_core_tb: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/mrrc_pkg.sv
hw/rtl/mrrc_crc16.sv
hw/rtl/mrrc_frame.sv
hw/rtl/modbus_register_reply_checker_core.sv
bench/mrrc_reply_monitor.sv
bench/modbus_register_reply_checker_core_tb.sv
